### rtl/core/assert_macros.svh
// Assertion macros shared by the orientation quaternion RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define TJOQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a consequent follows an antecedent on every edge outside reset.
`define TJOQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/core/tjoq_pkg.sv
// Types, constants and helper functions of the orientation quaternion core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package tjoq_pkg;

	// Angle handling, units of 0.005 degree of half-angle
	localparam logic signed [15:0] ANG_LIMIT_S = 16'sd18000;
	localparam logic [14:0]        ANG_LIMIT   = 15'd18000;
	localparam logic [14:0]        ANG_HALF    = 15'd9000;
	// round(pi / 36000 * 2^31)
	localparam logic [17:0]        RAD_K       = 18'd187403;
	localparam logic [31:0]        Q31_ONE     = 32'h8000_0000;
	localparam logic [14:0]        Q15_MAX     = 15'd32767;

	// Horner chain: one cell per term, three register stages per cell
	localparam int unsigned N_CELLS     = 5;
	localparam int unsigned CELL_STAGES = 3;
	localparam int unsigned PIPE_STAGES = 3 + CELL_STAGES * N_CELLS + 2;
	localparam int unsigned COS_DIV [N_CELLS] = '{90, 56, 30, 12, 2};
	localparam int unsigned SIN_DIV [N_CELLS] = '{1, 72, 42, 20, 6};
	localparam bit          SIN_STEP [N_CELLS] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

	localparam int unsigned OUT_DEPTH_DEF = 32;

	typedef struct packed {
		logic signed [15:0] pan_angle;
		logic signed [15:0] tilt_angle;
	} tjoq_in_t;

	typedef struct packed {
		logic [14:0]        quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} tjoq_out_t;

	// One angle's data as it moves along the cell row
	typedef struct packed {
		logic [30:0] x;
		logic [30:0] x2;
		logic [31:0] s;
		logic [31:0] c;
	} tjoq_lane_t;

	// Folded angle: reduced to [0, 45] degrees of half-angle
	typedef struct packed {
		logic        neg;
		logic        swap;
		logic        nz;
		logic [13:0] v;
	} tjoq_fold_t;

	typedef struct packed {
		logic pan_neg;
		logic pan_swap;
		logic tilt_neg;
		logic tilt_swap;
		logic tilt_nz;
	} tjoq_side_t;

	function automatic tjoq_fold_t fold_angle(input logic signed [15:0] a);
		logic signed [15:0] cl;
		logic [14:0]        mag;
		tjoq_fold_t         f;
		if (a > ANG_LIMIT_S) begin
			cl = ANG_LIMIT_S;
		end else if (a < -ANG_LIMIT_S) begin
			cl = -ANG_LIMIT_S;
		end else begin
			cl = a;
		end
		f.neg  = cl[15];
		mag    = f.neg ? 15'(-cl) : cl[14:0];
		f.nz   = (mag != '0);
		f.swap = (mag > ANG_HALF);
		f.v    = f.swap ? 14'(ANG_LIMIT - mag) : mag[13:0];
		return f;
	endfunction

	// Round a Q62 magnitude to Q15 and saturate
	function automatic logic [14:0] to_q15(input logic [63:0] p);
		logic [63:0] sum;
		logic [16:0] r;
		sum = p + (64'd1 << 46);
		r   = sum[63:47];
		return (r > {2'b00, Q15_MAX}) ? Q15_MAX : r[14:0];
	endfunction

	function automatic logic signed [15:0] apply_sign(input logic [14:0] mag, input logic neg);
		logic [15:0] m16;
		m16 = {1'b0, mag};
		return neg ? -m16 : m16;
	endfunction

endpackage

### rtl/core/tjoq_cell.sv
// One Horner step for sine and cosine of a single angle, three stages deep.
// Depends on tjoq_pkg for the lane type and the Q31 constant.
`timescale 1ns / 1ps

module tjoq_cell import tjoq_pkg::*; #(
	parameter int unsigned K_SIN  = 72,
	parameter int unsigned K_COS  = 90,
	parameter bit          SIN_EN = 1'b1
) (
	input  logic       clk,
	input  tjoq_lane_t lane_in,
	output tjoq_lane_t lane_out
);

	// floor(2^32 / k): the estimate is at most one below the true quotient
	localparam logic [31:0] RECIP_SIN = 32'((64'd1 << 32) / K_SIN);
	localparam logic [31:0] RECIP_COS = 32'((64'd1 << 32) / K_COS);
	localparam logic [7:0]  KS        = 8'(K_SIN);
	localparam logic [7:0]  KC        = 8'(K_COS);

	logic [62:0] prod_s, prod_c;
	logic [62:0] est_s, est_c;
	logic [38:0] kq_s, kq_c;
	logic [30:0] rem_s, rem_c;
	logic [30:0] quo_s, quo_c;

	logic [30:0] x_s1, x2_s1, ts_s1, tc_s1;
	logic [31:0] s_s1;
	logic [30:0] x_s2, x2_s2, ts_s2, tc_s2, qs_s2, qc_s2;
	logic [31:0] s_s2;
	tjoq_lane_t  lane_s3;

	// Stage 1: x2 times the running term
	assign prod_s = 63'(lane_in.x2) * 63'(lane_in.s);
	assign prod_c = 63'(lane_in.x2) * 63'(lane_in.c);

	always_ff @(posedge clk) begin
		x_s1  <= lane_in.x;
		x2_s1 <= lane_in.x2;
		s_s1  <= lane_in.s;
		ts_s1 <= prod_s[61:31];
		tc_s1 <= prod_c[61:31];
	end

	// Stage 2: quotient estimate by reciprocal
	assign est_s = 63'(ts_s1) * 63'(RECIP_SIN);
	assign est_c = 63'(tc_s1) * 63'(RECIP_COS);

	always_ff @(posedge clk) begin
		x_s2  <= x_s1;
		x2_s2 <= x2_s1;
		s_s2  <= s_s1;
		ts_s2 <= ts_s1;
		tc_s2 <= tc_s1;
		qs_s2 <= est_s[62:32];
		qc_s2 <= est_c[62:32];
	end

	// Stage 3: correct the estimate by one where the remainder allows
	assign kq_s  = 39'(qs_s2) * 39'(KS);
	assign kq_c  = 39'(qc_s2) * 39'(KC);
	assign rem_s = ts_s2 - kq_s[30:0];
	assign rem_c = tc_s2 - kq_c[30:0];
	assign quo_s = qs_s2 + 31'(rem_s >= 31'(KS));
	assign quo_c = qc_s2 + 31'(rem_c >= 31'(KC));

	always_ff @(posedge clk) begin
		lane_s3.x  <= x_s2;
		lane_s3.x2 <= x2_s2;
		lane_s3.s  <= SIN_EN ? (Q31_ONE - {1'b0, quo_s}) : s_s2;
		lane_s3.c  <= Q31_ONE - {1'b0, quo_c};
	end

	assign lane_out = lane_s3;

endmodule

### rtl/core/tjoq_out_fifo.sv
// Output queue holding finished quaternions until the consumer takes them.
// Depends on tjoq_pkg for the result type and assert_macros.svh for checks.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tjoq_out_fifo import tjoq_pkg::*; #(
	parameter int unsigned DEPTH = OUT_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tjoq_out_t push_data,
	output logic      pop_valid,
	input  logic      pop_ready,
	output tjoq_out_t pop_data
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	tjoq_out_t          mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               out_valid_q;
	tjoq_out_t          out_q;
	logic               pop;
	logic               load;

	assign pop       = out_valid_q && pop_ready;
	// Refill the output register from the queue when it holds an entry and the register is empty or being taken
	assign load      = (count_q != '0) && (!out_valid_q || pop_ready);
	assign pop_valid = out_valid_q;
	assign pop_data  = out_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
		if (load) begin
			out_q <= mem_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (load) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !load) begin
				count_q <= count_q + 1'b1;
			end else if (load && !push) begin
				count_q <= count_q - 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`TJOQ_ASSERT_IMP(a_no_overflow, clk, arst_n, push, (count_q != CNT_W'(DEPTH)) || load, "queue overflow")
	`TJOQ_ASSERT_IMP(a_empty_ptrs, clk, arst_n, count_q == '0, wr_ptr_q == rd_ptr_q, "pointers apart on empty queue")
	`TJOQ_ASSERT(a_out_held, clk, arst_n, pop_valid && !pop_ready |=> pop_valid && $stable(pop_data), "output beat dropped")

endmodule

### rtl/core/two_joint_orientation_quaternion_core.sv
// Throughput: one beat per cycle through the 20-stage pipeline; the output queue of
// FIFO_DEPTH entries limits beats in flight, so FIFO_DEPTH of 23 or more keeps full rate.
// Reset clears the stage valid line, the in-flight count, the queue pointers and the queue
// output flag; datapath registers are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module two_joint_orientation_quaternion_core import tjoq_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = OUT_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      angle_valid,
	output logic      angle_ready,
	input  tjoq_in_t  angle,
	output logic      quat_valid,
	input  logic      quat_ready,
	output tjoq_out_t quat
);

	localparam int unsigned OCC_W = $clog2(FIFO_DEPTH + 1);

	logic             acc_in, acc_out;
	logic [OCC_W-1:0] occ_q;

	tjoq_fold_t  pan_f, tilt_f;
	logic        valid_q [PIPE_STAGES];
	tjoq_side_t  side_q  [PIPE_STAGES];
	tjoq_side_t  side_last;

	logic [13:0] v_pan_s1, v_tilt_s1;
	logic [31:0] xp_pan, xp_tilt;
	logic [30:0] x_pan_s2, x_tilt_s2;
	logic [61:0] sq_pan, sq_tilt;
	tjoq_lane_t  lane_pan  [N_CELLS+1];
	tjoq_lane_t  lane_tilt [N_CELLS+1];

	logic [62:0] sp_pan, sp_tilt;
	logic [31:0] sin_pan_s19, cos_pan_s19, sin_tilt_s19, cos_tilt_s19;
	logic [31:0] sa, ca, sb, cb;
	logic [63:0] pw_s20, px_s20, py_s20, pz_s20;
	tjoq_out_t   result;

	assign acc_in      = angle_valid && angle_ready;
	assign acc_out     = quat_valid && quat_ready;
	assign angle_ready = (occ_q < OCC_W'(FIFO_DEPTH));

	// Count beats accepted and not yet delivered; this reserves a queue entry for each
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (acc_in && !acc_out) begin
			occ_q <= occ_q + 1'b1;
		end else if (acc_out && !acc_in) begin
			occ_q <= occ_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_STAGES; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			valid_q[0] <= acc_in;
			for (int i = 1; i < PIPE_STAGES; i++) begin
				valid_q[i] <= valid_q[i-1];
			end
		end
	end

	// Stage 1: clamp and fold each angle
	assign pan_f  = fold_angle(angle.pan_angle);
	assign tilt_f = fold_angle(angle.tilt_angle);

	always_ff @(posedge clk) begin
		v_pan_s1            <= pan_f.v;
		v_tilt_s1           <= tilt_f.v;
		side_q[0].pan_neg   <= pan_f.neg;
		side_q[0].pan_swap  <= pan_f.swap;
		side_q[0].tilt_neg  <= tilt_f.neg;
		side_q[0].tilt_swap <= tilt_f.swap;
		side_q[0].tilt_nz   <= tilt_f.nz;
		for (int i = 1; i < PIPE_STAGES; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	// Stage 2: angle in radians, Q31
	assign xp_pan  = 32'(v_pan_s1) * 32'(RAD_K);
	assign xp_tilt = 32'(v_tilt_s1) * 32'(RAD_K);

	always_ff @(posedge clk) begin
		x_pan_s2  <= xp_pan[30:0];
		x_tilt_s2 <= xp_tilt[30:0];
	end

	// Stage 3: square, and seed both Horner terms with one
	assign sq_pan  = 62'(x_pan_s2) * 62'(x_pan_s2);
	assign sq_tilt = 62'(x_tilt_s2) * 62'(x_tilt_s2);

	always_ff @(posedge clk) begin
		lane_pan[0]  <= '{x: x_pan_s2, x2: sq_pan[61:31], s: Q31_ONE, c: Q31_ONE};
		lane_tilt[0] <= '{x: x_tilt_s2, x2: sq_tilt[61:31], s: Q31_ONE, c: Q31_ONE};
	end

	for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
		tjoq_cell #(
			.K_SIN  (SIN_DIV[g]),
			.K_COS  (COS_DIV[g]),
			.SIN_EN (SIN_STEP[g])
		) u_cell_pan (
			.clk      (clk),
			.lane_in  (lane_pan[g]),
			.lane_out (lane_pan[g+1])
		);
		tjoq_cell #(
			.K_SIN  (SIN_DIV[g]),
			.K_COS  (COS_DIV[g]),
			.SIN_EN (SIN_STEP[g])
		) u_cell_tilt (
			.clk      (clk),
			.lane_in  (lane_tilt[g]),
			.lane_out (lane_tilt[g+1])
		);
	end

	// Stage 19: finish the sine with its leading factor of x
	assign sp_pan  = 63'(lane_pan[N_CELLS].x) * 63'(lane_pan[N_CELLS].s);
	assign sp_tilt = 63'(lane_tilt[N_CELLS].x) * 63'(lane_tilt[N_CELLS].s);

	always_ff @(posedge clk) begin
		sin_pan_s19  <= sp_pan[62:31];
		cos_pan_s19  <= lane_pan[N_CELLS].c;
		sin_tilt_s19 <= sp_tilt[62:31];
		cos_tilt_s19 <= lane_tilt[N_CELLS].c;
	end

	// Stage 20: undo the swap of the fold, then the four cross products
	assign side_last = side_q[PIPE_STAGES-2];
	assign sa = side_last.pan_swap  ? cos_pan_s19  : sin_pan_s19;
	assign ca = side_last.pan_swap  ? sin_pan_s19  : cos_pan_s19;
	assign sb = side_last.tilt_swap ? cos_tilt_s19 : sin_tilt_s19;
	assign cb = side_last.tilt_swap ? sin_tilt_s19 : cos_tilt_s19;

	always_ff @(posedge clk) begin
		pw_s20 <= 64'(ca) * 64'(cb);
		px_s20 <= 64'(sa) * 64'(sb);
		py_s20 <= 64'(ca) * 64'(sb);
		pz_s20 <= 64'(sa) * 64'(cb);
	end

	// Round, saturate and sign; the queue entry is the last register
	always_comb begin
		result.quat_w = to_q15(pw_s20);
		result.quat_x = apply_sign(to_q15(px_s20),
			side_q[PIPE_STAGES-1].pan_neg != side_q[PIPE_STAGES-1].tilt_neg);
		result.quat_y = apply_sign(to_q15(py_s20),
			!side_q[PIPE_STAGES-1].tilt_neg && side_q[PIPE_STAGES-1].tilt_nz);
		result.quat_z = apply_sign(to_q15(pz_s20), side_q[PIPE_STAGES-1].pan_neg);
	end

	tjoq_out_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_q[PIPE_STAGES-1]),
		.push_data (result),
		.pop_valid (quat_valid),
		.pop_ready (quat_ready),
		.pop_data  (quat)
	);

	`TJOQ_ASSERT(a_occ_bound, clk, arst_n, occ_q <= OCC_W'(FIFO_DEPTH), "in-flight count above queue depth")
	`TJOQ_ASSERT_IMP(a_out_counted, clk, arst_n, quat_valid, occ_q != '0, "output beat with nothing in flight")
	`TJOQ_ASSERT_IMP(a_latency, clk, arst_n, acc_in, ##(PIPE_STAGES) valid_q[PIPE_STAGES-1], "accepted beat did not reach the last stage")

endmodule
